@@ rtl/pad_pkg.sv @@
// ============================================================================
// pad_pkg: shared constants, types and angle table for the polar angle unit
// Holds the widths of the coordinate and CORDIC datapaths, the control word
// that travels down the pipeline, and the arctangent table in degrees.
// ============================================================================
`default_nettype none

package pad_pkg;

  // Coordinate and result formats
  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int ITERATIONS      = 16;
  localparam int ANGLE_W         = 16;

  // Internal fixed-point formats
  localparam int ACC_FRAC    = 20;
  localparam int PRESCALE    = 24;
  localparam int TABLE_LEN   = 24;
  localparam int NUM_STEPS   = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
  localparam int STEP_IDX_W  = $clog2(TABLE_LEN);

  // Difference of two coordinates, then prescaled and grown by CORDIC gain
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int XW     = DIFF_W + PRESCALE + 3;

  // Angle accumulator: degrees * 2^ACC_FRAC, signed, room for -180..+540
  localparam int ZW     = ACC_FRAC + 11;
  localparam int TOT_W  = ZW - 1;

  // Rounding from accumulator units to output units
  localparam int RND_SH  = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int RND_W   = TOT_W + 1 - RND_SH;

  localparam logic signed [ZW-1:0] FULL_TURN = ZW'(64'sd360 <<< ACC_FRAC);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd180 <<< ACC_FRAC);
  localparam logic [TOT_W:0]       RND_HALF  = (TOT_W+1)'(64'd1 << (RND_SH - 1));
  localparam logic [RND_W-1:0]     RND_FULL  = RND_W'(64'd360 << ANGLE_FRAC_BITS);

  // Axis angles in output units, masked to the output width
  localparam logic [ANGLE_W-1:0] ANG_0   = '0;
  localparam logic [ANGLE_W-1:0] ANG_90  = ANGLE_W'(64'd90 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_W-1:0] ANG_180 = ANGLE_W'(64'd180 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_W-1:0] ANG_270 = ANGLE_W'(64'd270 << ANGLE_FRAC_BITS);

  // Control word that rides along with each item
  typedef struct packed {
    logic               valid;
    logic               bypass;     // point on an axis or coincident
    logic               coinc;
    logic [ANGLE_W-1:0] axis_angle;
  } pad_ctl_t;

  // CORDIC vector and angle accumulator
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } pad_vec_t;

  // atan(2^-i) in degrees * 2^20, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q20(input logic [STEP_IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    v = '0;
    unique case (idx)
      5'd0:    v = ZW'(47185920);
      5'd1:    v = ZW'(27855475);
      5'd2:    v = ZW'(14718068);
      5'd3:    v = ZW'(7471121);
      5'd4:    v = ZW'(3750058);
      5'd5:    v = ZW'(1876857);
      5'd6:    v = ZW'(938658);
      5'd7:    v = ZW'(469357);
      5'd8:    v = ZW'(234682);
      5'd9:    v = ZW'(117342);
      5'd10:   v = ZW'(58671);
      5'd11:   v = ZW'(29335);
      5'd12:   v = ZW'(14668);
      5'd13:   v = ZW'(7334);
      5'd14:   v = ZW'(3667);
      5'd15:   v = ZW'(1833);
      5'd16:   v = ZW'(917);
      5'd17:   v = ZW'(458);
      5'd18:   v = ZW'(229);
      5'd19:   v = ZW'(115);
      5'd20:   v = ZW'(57);
      5'd21:   v = ZW'(29);
      5'd22:   v = ZW'(14);
      5'd23:   v = ZW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pad_prep.sv @@
// ============================================================================
// pad_prep: difference, axis detection and half-plane reflection
// Forms dx and dy, flags points on an axis or at the center, reflects the
// vector into the right half plane and prescales it for the CORDIC.
// ============================================================================
`default_nettype none

module pad_prep (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      accept,
  input  wire logic signed [pad_pkg::COORD_WIDTH-1:0]    first_x,
  input  wire logic signed [pad_pkg::COORD_WIDTH-1:0]    first_y,
  input  wire logic signed [pad_pkg::COORD_WIDTH-1:0]    center_x,
  input  wire logic signed [pad_pkg::COORD_WIDTH-1:0]    center_y,
  output pad_pkg::pad_ctl_t                              ctl_o,
  output pad_pkg::pad_vec_t                              vec_o
);
  import pad_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy, rx, ry;
  logic                     dx_zero, dy_zero, dx_neg;
  pad_ctl_t                 ctl_r, ctl_nxt;
  pad_vec_t                 vec_r, vec_nxt;

  // Form exact differences
  assign dx = DIFF_W'(first_x) - DIFF_W'(center_x);
  assign dy = DIFF_W'(first_y) - DIFF_W'(center_y);
  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);
  assign dx_neg  = dx[DIFF_W-1];

  // Reflect into the right half plane
  assign rx = dx_neg ? -dx : dx;
  assign ry = dx_neg ? -dy : dy;

  // Classify and build the next word
  always_comb begin
    ctl_nxt.valid  = accept;
    ctl_nxt.bypass = dx_zero | dy_zero;
    ctl_nxt.coinc  = dx_zero & dy_zero;
    priority if (dx_zero && dy_zero) begin
      ctl_nxt.axis_angle = ANG_0;
    end else if (dx_zero) begin
      ctl_nxt.axis_angle = dy[DIFF_W-1] ? ANG_270 : ANG_90;
    end else begin
      ctl_nxt.axis_angle = dx_neg ? ANG_180 : ANG_0;
    end
    vec_nxt.x = XW'(rx) <<< PRESCALE;
    vec_nxt.y = XW'(ry) <<< PRESCALE;
    vec_nxt.z = dx_neg ? HALF_TURN : '0;
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.bypass     <= ctl_nxt.bypass;
    ctl_r.coinc      <= ctl_nxt.coinc;
    ctl_r.axis_angle <= ctl_nxt.axis_angle;
    vec_r            <= vec_nxt;
  end

  assign ctl_o = ctl_r;
  assign vec_o = vec_r;

endmodule

`default_nettype wire

@@ rtl/pad_cordic.sv @@
// ============================================================================
// pad_cordic: unrolled vectoring CORDIC, one register stage per step
// Each stage rotates the vector toward the +x axis by atan(2^-i) and
// accumulates the rotation in degrees; control words travel alongside.
// ============================================================================
`default_nettype none

module pad_cordic (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pad_pkg::pad_ctl_t ctl_i,
  input  wire pad_pkg::pad_vec_t vec_i,
  output pad_pkg::pad_ctl_t      ctl_o,
  output pad_pkg::pad_vec_t      vec_o
);
  import pad_pkg::*;

  pad_ctl_t ctl_r [NUM_STEPS];
  pad_vec_t vec_r [NUM_STEPS];

  for (genvar gi = 0; gi < NUM_STEPS; gi++) begin : g_step
    pad_ctl_t             src_ctl;
    pad_vec_t             src;
    pad_vec_t             vec_nxt;
    logic signed [XW-1:0] xs, ys;
    logic                 y_pos;

    // Pick the stage source
    if (gi == 0) begin : g_first
      assign src_ctl = ctl_i;
      assign src     = vec_i;
    end else begin : g_rest
      assign src_ctl = ctl_r[gi-1];
      assign src     = vec_r[gi-1];
    end

    // Rotate by one micro-angle
    always_comb begin
      xs    = src.x >>> gi;
      ys    = src.y >>> gi;
      y_pos = !src.y[XW-1] && (src.y != '0);
      if (y_pos) begin
        vec_nxt.x = src.x + ys;
        vec_nxt.y = src.y - xs;
        vec_nxt.z = src.z + atan_q20(STEP_IDX_W'(gi));
      end else begin
        vec_nxt.x = src.x - ys;
        vec_nxt.y = src.y + xs;
        vec_nxt.z = src.z - atan_q20(STEP_IDX_W'(gi));
      end
    end

    // Advance one stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[gi].valid <= 1'b0;
      end else begin
        ctl_r[gi].valid <= src_ctl.valid;
      end
      ctl_r[gi].bypass     <= src_ctl.bypass;
      ctl_r[gi].coinc      <= src_ctl.coinc;
      ctl_r[gi].axis_angle <= src_ctl.axis_angle;
      vec_r[gi]            <= vec_nxt;
    end
  end

  assign ctl_o = ctl_r[NUM_STEPS-1];
  assign vec_o = vec_r[NUM_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/pad_post.sv @@
// ============================================================================
// pad_post: wrap and round of the accumulated angle
// First stage brings the angle into one turn, second stage rounds to the
// output units, wraps a full turn to zero and selects the axis result.
// ============================================================================
`default_nettype none

module pad_post (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pad_pkg::pad_ctl_t             ctl_i,
  input  wire pad_pkg::pad_vec_t             vec_i,
  output logic                               valid_o,
  output logic [pad_pkg::ANGLE_W-1:0]        angle_o,
  output logic                               coinc_o
);
  import pad_pkg::*;

  logic signed [ZW-1:0] wrap_a, wrap_b;
  logic [TOT_W-1:0]     tot_r, tot_nxt;
  pad_ctl_t             ctl_r;
  logic [TOT_W:0]       rsum;
  logic [RND_W-1:0]     rnd;
  logic [ANGLE_W-1:0]   angle_nxt;
  logic                 valid_r;
  logic [ANGLE_W-1:0]   angle_r;
  logic                 coinc_r;

  // Wrap into [0, 360) degrees
  always_comb begin
    wrap_a  = vec_i.z[ZW-1] ? (vec_i.z + FULL_TURN) : vec_i.z;
    wrap_b  = (wrap_a >= FULL_TURN) ? (wrap_a - FULL_TURN) : wrap_a;
    tot_nxt = wrap_b[TOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.bypass     <= ctl_i.bypass;
    ctl_r.coinc      <= ctl_i.coinc;
    ctl_r.axis_angle <= ctl_i.axis_angle;
    tot_r            <= tot_nxt;
  end

  // Round half up, wrap a full turn to zero, pick the axis result
  always_comb begin
    rsum = {1'b0, tot_r} + RND_HALF;
    rnd  = rsum[TOT_W:RND_SH];
    if (rnd >= RND_FULL) begin
      rnd = rnd - RND_FULL;
    end
    angle_nxt = ctl_r.bypass ? ctl_r.axis_angle : ANGLE_W'(rnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_r.valid;
    end
    angle_r <= angle_nxt;
    coinc_r <= ctl_r.coinc;
  end

  assign valid_o = valid_r;
  assign angle_o = angle_r;
  assign coinc_o = coinc_r;

endmodule

`default_nettype wire

@@ rtl/polar_angle_degrees_unit.sv @@
// ============================================================================
// polar_angle_degrees_unit: polar angle of a point about a center point
// Gives the counterclockwise angle from +x in 1/128 degree units through a
// prescaled vectoring CORDIC, with exact results for points on an axis.
// ============================================================================
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-------------------
//  input    | in_first_x/y, in_center_x/y (16 b signed)    | start, busy
//  result   | out_angle (16 b), out_coincident (1 b)       | out_valid strobe
//
//  One word is taken every cycle; busy is never raised.
//  The pipeline has one prep stage, one
//  stage per CORDIC step, then a wrap stage and a round stage.
//  Synchronous active-low reset clears all valid bits; nothing else resets.
//  The receiver takes each result in its strobe cycle and cannot stall.
// ============================================================================
`default_nettype none

module polar_angle_degrees_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [pad_pkg::COORD_WIDTH-1:0] in_first_x,
  input  wire logic signed [pad_pkg::COORD_WIDTH-1:0] in_first_y,
  input  wire logic signed [pad_pkg::COORD_WIDTH-1:0] in_center_x,
  input  wire logic signed [pad_pkg::COORD_WIDTH-1:0] in_center_y,
  output logic                                        out_valid,
  output logic [pad_pkg::ANGLE_W-1:0]                 out_angle,
  output logic                                        out_coincident
);
  import pad_pkg::*;

  localparam int LATENCY = NUM_STEPS + 3;

  pad_ctl_t prep_ctl, cord_ctl;
  pad_vec_t prep_vec, cord_vec;
  logic     accept;

  // Pipeline always takes a word
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  pad_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .ctl_o    (prep_ctl),
    .vec_o    (prep_vec)
  );

  pad_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (prep_ctl),
    .vec_i (prep_vec),
    .ctl_o (cord_ctl),
    .vec_o (cord_vec)
  );

  pad_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (cord_ctl),
    .vec_i   (cord_vec),
    .valid_o (out_valid),
    .angle_o (out_angle),
    .coinc_o (out_coincident)
  );

  // Every result comes from a word taken in at the pipeline input
  a_valid_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result strobe without a matching input word");

  // Coincident flag follows the inputs of that word
  a_coinc_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coincident == $past((in_first_x == in_center_x) &&
                                           (in_first_y == in_center_y), LATENCY)))
    else $error("coincident flag does not match the input word");

  // Coincident points give angle zero
  a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coincident) |-> (out_angle == ANG_0))
    else $error("coincident result with nonzero angle");

  // Angle stays below a full turn where the output width holds it
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((ANGLE_FRAC_BITS > 7) || (32'(out_angle) < (32'd360 << ANGLE_FRAC_BITS))))
    else $error("angle at or above a full turn");

endmodule

`default_nettype wire
